[hdl/mmr_pkg.sv]
`timescale 1ns / 1ps
package mmr_pkg;

  localparam int DW        = 48;            // word width
  localparam int FW        = 24;            // fraction bits
  localparam int MAX_TERMS = 6;
  localparam int LW        = DW / 2;        // low half for partial products
  localparam int UW        = DW - LW;       // high half
  localparam int N_CFG     = 2 + MAX_TERMS;
  localparam int CFG_IW    = $clog2(N_CFG);
  localparam int NW        = $clog2(MAX_TERMS + 1);
  localparam int XW        = 2 * DW + 1;    // full product plus carry

  typedef logic signed [DW-1:0] fx_t;
  typedef logic [XW-1:0] xw_t;

  localparam fx_t FX_ONE = {{(DW-FW-1){1'b0}}, 1'b1, {FW{1'b0}}};
  localparam fx_t FX_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam xw_t X_LIM  = xw_t'(1) << (DW - 1);
  localparam xw_t X_HALF = xw_t'(1) << (FW - 1);

  typedef enum logic [2:0] {
    MODE_RAT   = 3'd0,
    MODE_QUAD  = 3'd1,
    MODE_RK    = 3'd2,
    MODE_GUG   = 3'd3,
    MODE_TW    = 3'd4,
    MODE_CONST = 3'd5
  } mode_e;

  localparam logic [CFG_IW-1:0] CFG_MODE  = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_TERMS = CFG_IW'(1);
  localparam int                CFG_PARAM0 = 2;

  typedef struct packed {
    fx_t  x_first;
    fx_t  x_second;
    fx_t  measured;
    fx_t  scale;
    logic last_point;
  } in_word_t;

  typedef struct packed {
    fx_t  fitted;
    fx_t  residual;
    fx_t  basis_0;
    fx_t  basis_1;
    fx_t  basis_2;
    fx_t  basis_3;
    fx_t  basis_4;
    fx_t  basis_5;
    logic divide_fault;
    logic last_out;
  } out_word_t;

  // partial products of one magnitude multiply
  typedef struct packed {
    logic          neg;
    logic [2*UW-1:0] p00;
    logic [2*UW-1:0] p01;
    logic [2*UW-1:0] p10;
    logic [2*UW-1:0] p11;
  } mpp_t;

  function automatic logic [DW-1:0] fx_mag(fx_t a);
    return a[DW-1] ? (~a + 1'b1) : a;
  endfunction

  // magnitude to signed word, saturating
  function automatic fx_t sat_mag(logic neg, xw_t m);
    logic [DW-1:0] lo;
    lo = m[DW-1:0];
    if (m >= X_LIM) return neg ? FX_MIN : FX_MAX;
    return neg ? fx_t'(-lo) : fx_t'(lo);
  endfunction

  function automatic fx_t sadd(fx_t a, fx_t b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? FX_MIN : FX_MAX;
    return fx_t'(s[DW-1:0]);
  endfunction

  function automatic fx_t ssub(fx_t a, fx_t b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? FX_MIN : FX_MAX;
    return fx_t'(s[DW-1:0]);
  endfunction

  function automatic mpp_t fmul_pp(fx_t a, fx_t b);
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;
    mpp_t r;
    ma = fx_mag(a);
    mb = fx_mag(b);
    r.neg = a[DW-1] ^ b[DW-1];
    r.p00 = ma[LW-1:0] * mb[LW-1:0];
    r.p01 = ma[LW-1:0] * mb[DW-1:LW];
    r.p10 = ma[DW-1:LW] * mb[LW-1:0];
    r.p11 = ma[DW-1:LW] * mb[DW-1:LW];
    return r;
  endfunction

  // sum partials, round half away from zero, saturate
  function automatic fx_t fmul_fin(mpp_t p);
    xw_t full;
    xw_t rnd;
    full = (xw_t'(p.p11) << (2 * LW)) + (xw_t'(p.p01) << LW)
         + (xw_t'(p.p10) << LW) + xw_t'(p.p00);
    rnd = (full + X_HALF) >> FW;
    return sat_mag(p.neg, rnd);
  endfunction

endpackage

[hdl/mixing_model_residual.sv]
`timescale 1ns / 1ps
// Residual and basis evaluator for a binary-mixture excess model.
// Input: one word per point on in_word, taken at a clock edge with start high
//   and busy low. busy is always low: a point can be given every cycle.
// Output: out_word is valid for exactly one cycle while out_strobe is high.
//   The receiver must take it then; words leave in the order they came in.
// Throughput: one word per cycle, fixed. The pipeline depth is set by the
//   restoring divider (one quotient bit per stage) behind the multiply chain
//   (two stages per multiply level).
// Config: cfg_we/cfg_idx/cfg_wdata write mode, term_count and param_0..5;
//   write only while no point is in flight.
// Reset (rst_n low, synchronous): mode = Guggenheim, term_count = 3,
//   params = 0, pipeline emptied. No clearing pass.
// Pipeline: input reg, three side multiply levels (prod, rational terms,
//   Thompson-Waldbaum), MAX_TERMS-1 power-chain levels, three post levels
//   (sum*t0, *t1, *scale), divider prep, DW divider steps, rounding, output.
module mixing_model_residual
  import mmr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_word_t            in_word,
  output logic                out_strobe,
  output out_word_t           out_word,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_idx,
  input  fx_t                 cfg_wdata
);

  // word carried through the multiply pipeline
  typedef struct packed {
    logic last;
    fx_t  t0;
    fx_t  t1;
    fx_t  base;   // power chain base: t0 or t0 - t1
    fx_t  bfac;   // basis factor: prod or one
    fx_t  meas;
    fx_t  scale;
    fx_t  prod;
    fx_t  u1;
    fx_t  u2;
    fx_t  u3;
    fx_t  u4;
    fx_t  v2;
    fx_t  v3;
    fx_t  w;
    fx_t  m4b0;
    fx_t  m4b1;
    fx_t  z;
    fx_t  fit1;
    fx_t  num;
    fx_t  den;
    fx_t  pw;
    fx_t  acc;
    fx_t  y;
    fx_t [MAX_TERMS-1:0] b;
  } pl_t;

  typedef struct packed {
    logic last;
    logic rat;
    fx_t  meas;
    fx_t  fit;
    fx_t  num;
    fx_t  den;
    fx_t [MAX_TERMS-1:0] b;
  } tl_t;

  typedef struct packed {
    logic          last;
    logic          rat;
    logic          qneg;
    logic          dz;
    logic          ovf;
    fx_t           meas;
    fx_t           fit;
    fx_t [MAX_TERMS-1:0] b;
    logic [DW-1:0] nm;
    logic [DW-1:0] dm;
    logic [DW-1:0] rem;
    logic [DW-1:0] q;
  } dv_t;

  // ---------------- configuration ----------------
  logic [2:0]  mode_r;
  logic [2:0]  terms_r;
  fx_t         param_r [MAX_TERMS];
  fx_t         c_r;     // 1 - p0 + p1 + p2 for the rational model
  fx_t         p2_w;
  logic [NW-1:0] n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_GUG;
      terms_r <= 3'd3;
      for (int k = 0; k < MAX_TERMS; k++) param_r[k] <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_MODE) mode_r <= cfg_wdata[2:0];
      if (cfg_idx == CFG_TERMS) terms_r <= cfg_wdata[2:0];
      for (int k = 0; k < MAX_TERMS; k++) begin
        if (cfg_idx == CFG_IW'(CFG_PARAM0 + k)) param_r[k] <= cfg_wdata;
      end
    end
  end

  generate
    if (MAX_TERMS > 2) begin : g_p2
      assign p2_w = param_r[2];
    end else begin : g_nop2
      assign p2_w = '0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    c_r <= sadd(sadd(ssub(FX_ONE, param_r[0]), param_r[1]), p2_w);
  end

  always_comb begin
    if (terms_r == '0) n_eff = NW'(1);
    else if (int'(terms_r) > MAX_TERMS) n_eff = NW'(MAX_TERMS);
    else n_eff = NW'(terms_r);
  end

  logic is_01, is_23, is_tw;
  assign is_01 = (mode_r == MODE_RAT) || (mode_r == MODE_QUAD);
  assign is_23 = (mode_r == MODE_RK) || (mode_r == MODE_GUG);
  assign is_tw = (mode_r == MODE_TW);

  assign busy = 1'b0;

  // ---------------- input register ----------------
  logic s0_v_r;
  pl_t  s0_r, s0_nxt;

  always_comb begin
    s0_nxt       = '0;
    s0_nxt.last  = in_word.last_point;
    s0_nxt.t0    = in_word.x_first;
    s0_nxt.t1    = in_word.x_second;
    s0_nxt.meas  = in_word.measured;
    s0_nxt.scale = in_word.scale;
    s0_nxt.base  = is_01 ? in_word.x_first : ssub(in_word.x_first, in_word.x_second);
  end

  // ---------------- level A: t0*t1, p1*t0, p2*t0, c*t0, p0*(t0|t1) ----------------
  logic pa_v_r, fa_v_r;
  pl_t  pa_r, fa_r, fa_nxt;
  mpp_t pa_pp_r [5];

  always_comb begin
    fa_nxt      = pa_r;
    fa_nxt.prod = fmul_fin(pa_pp_r[0]);
    fa_nxt.u1   = fmul_fin(pa_pp_r[1]);
    fa_nxt.u2   = fmul_fin(pa_pp_r[2]);
    fa_nxt.u3   = fmul_fin(pa_pp_r[3]);
    fa_nxt.u4   = fmul_fin(pa_pp_r[4]);
  end

  // ---------------- level B: rational squares, TW products ----------------
  logic pb_v_r, fb_v_r;
  pl_t  pb_r, fb_r, fb_nxt;
  mpp_t pb_pp_r [5];

  always_comb begin
    fb_nxt      = pb_r;
    fb_nxt.v2   = fmul_fin(pb_pp_r[0]);
    fb_nxt.v3   = fmul_fin(pb_pp_r[1]);
    fb_nxt.w    = fmul_fin(pb_pp_r[2]);
    fb_nxt.m4b0 = fmul_fin(pb_pp_r[3]);
    fb_nxt.m4b1 = fmul_fin(pb_pp_r[4]);
  end

  // ---------------- level C: TW fitted, rational sums, chain seed ----------------
  logic pc_v_r;
  pl_t  pc_r, pc_nxt;
  mpp_t pc_pp_r;

  always_comb begin
    pc_nxt      = fb_r;
    pc_nxt.num  = sadd(fb_r.u4, fb_r.v3);
    pc_nxt.den  = sadd(sadd(FX_ONE, fb_r.u1), fb_r.v2);
    pc_nxt.fit1 = sadd(sadd(param_r[0], fb_r.u1), fb_r.v2);
    pc_nxt.pw   = fb_r.base;
    pc_nxt.acc  = param_r[0];
    pc_nxt.bfac = is_23 ? fb_r.prod : FX_ONE;
    pc_nxt.b[0] = is_23 ? fb_r.prod : FX_ONE;
  end

  // cf_r[0] is the level C finish register, cf_r[j] ends chain level j
  logic cf_v_r [MAX_TERMS];
  pl_t  cf_r   [MAX_TERMS];
  pl_t  c0_nxt;

  always_comb begin
    c0_nxt   = pc_r;
    c0_nxt.z = fmul_fin(pc_pp_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r    <= 1'b0;
      pa_v_r    <= 1'b0;
      fa_v_r    <= 1'b0;
      pb_v_r    <= 1'b0;
      fb_v_r    <= 1'b0;
      pc_v_r    <= 1'b0;
      cf_v_r[0] <= 1'b0;
    end else begin
      s0_v_r    <= start & ~busy;
      pa_v_r    <= s0_v_r;
      fa_v_r    <= pa_v_r;
      pb_v_r    <= fa_v_r;
      fb_v_r    <= pb_v_r;
      pc_v_r    <= fb_v_r;
      cf_v_r[0] <= pc_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_r       <= s0_nxt;
    pa_r       <= s0_r;
    pa_pp_r[0] <= fmul_pp(s0_r.t0, s0_r.t1);
    pa_pp_r[1] <= fmul_pp(param_r[1], s0_r.t0);
    pa_pp_r[2] <= fmul_pp(p2_w, s0_r.t0);
    pa_pp_r[3] <= fmul_pp(c_r, s0_r.t0);
    pa_pp_r[4] <= fmul_pp(param_r[0], is_tw ? s0_r.t1 : s0_r.t0);
    fa_r       <= fa_nxt;
    pb_r       <= fa_r;
    pb_pp_r[0] <= fmul_pp(fa_r.u2, fa_r.t0);
    pb_pp_r[1] <= fmul_pp(fa_r.u3, fa_r.t0);
    pb_pp_r[2] <= fmul_pp(sadd(fa_r.u4, fa_r.u1), fa_r.t0);
    pb_pp_r[3] <= fmul_pp(fa_r.prod, fa_r.t1);
    pb_pp_r[4] <= fmul_pp(fa_r.prod, fa_r.t0);
    fb_r       <= fb_nxt;
    pc_r       <= pc_nxt;
    pc_pp_r    <= fmul_pp(fb_r.w, fb_r.t1);
    cf_r[0]    <= c0_nxt;
  end

  // ---------------- power chain: level j makes pw^(j+1), basis j, term j ----------------
  generate
    for (genvar j = 1; j < MAX_TERMS; j++) begin : g_chain
      logic cp_v_r;
      pl_t  cp_r, f_nxt;
      mpp_t cp_pp_r [3];

      always_comb begin
        f_nxt      = cp_r;
        f_nxt.pw   = fmul_fin(cp_pp_r[0]);
        f_nxt.b[j] = fmul_fin(cp_pp_r[1]);
        if (NW'(j) < n_eff) f_nxt.acc = sadd(cp_r.acc, fmul_fin(cp_pp_r[2]));
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cp_v_r    <= 1'b0;
          cf_v_r[j] <= 1'b0;
        end else begin
          cp_v_r    <= cf_v_r[j-1];
          cf_v_r[j] <= cp_v_r;
        end
      end

      always_ff @(posedge clk) begin
        cp_r       <= cf_r[j-1];
        cp_pp_r[0] <= fmul_pp(cf_r[j-1].pw, cf_r[j-1].base);
        cp_pp_r[1] <= fmul_pp(cf_r[j-1].bfac, cf_r[j-1].pw);
        cp_pp_r[2] <= fmul_pp(param_r[j], cf_r[j-1].pw);
        cf_r[j]    <= f_nxt;
      end
    end
  endgenerate

  // ---------------- post levels: sum*t0, *t1, scale ----------------
  logic g1p_v_r, g1f_v_r, g2p_v_r, g2f_v_r, g3p_v_r, g3f_v_r;
  pl_t  g1p_r, g1f_r, g2p_r, g2f_r, g3p_r;
  mpp_t g1_pp_r, g2_pp_r;
  mpp_t g3_pp_r [MAX_TERMS+1];
  pl_t  g1_nxt, g2_nxt;
  tl_t  g3f_r, g3_nxt;

  always_comb begin
    g1_nxt   = g1p_r;
    g1_nxt.y = fmul_fin(g1_pp_r);
    g2_nxt   = g2p_r;
    g2_nxt.y = fmul_fin(g2_pp_r);
  end

  always_comb begin
    g3_nxt      = '0;
    g3_nxt.last = g3p_r.last;
    g3_nxt.meas = g3p_r.meas;
    g3_nxt.num  = g3p_r.num;
    g3_nxt.den  = g3p_r.den;
    g3_nxt.rat  = (mode_r == MODE_RAT);
    g3_nxt.b    = g3p_r.b;
    unique case (mode_r)
      MODE_RAT:  g3_nxt.fit = '0;   // filled in after the divider
      MODE_QUAD: g3_nxt.fit = g3p_r.fit1;
      MODE_RK: begin
        g3_nxt.fit = fmul_fin(g3_pp_r[0]);
        for (int k = 0; k < MAX_TERMS; k++) g3_nxt.b[k] = fmul_fin(g3_pp_r[k+1]);
      end
      MODE_GUG:  g3_nxt.fit = g3p_r.y;
      MODE_TW: begin
        g3_nxt.fit  = g3p_r.z;
        g3_nxt.b[0] = g3p_r.m4b0;
        g3_nxt.b[1] = g3p_r.m4b1;
      end
      default:   g3_nxt.fit = FX_ONE;
    endcase
    // unused basis terms read zero
    for (int k = 0; k < MAX_TERMS; k++) begin
      if (!(((is_01 || is_23) && (NW'(k) < n_eff)) || (is_tw && k < 2)))
        g3_nxt.b[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1p_v_r <= 1'b0;
      g1f_v_r <= 1'b0;
      g2p_v_r <= 1'b0;
      g2f_v_r <= 1'b0;
      g3p_v_r <= 1'b0;
      g3f_v_r <= 1'b0;
    end else begin
      g1p_v_r <= cf_v_r[MAX_TERMS-1];
      g1f_v_r <= g1p_v_r;
      g2p_v_r <= g1f_v_r;
      g2f_v_r <= g2p_v_r;
      g3p_v_r <= g2f_v_r;
      g3f_v_r <= g3p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    g1p_r      <= cf_r[MAX_TERMS-1];
    g1_pp_r    <= fmul_pp(cf_r[MAX_TERMS-1].acc, cf_r[MAX_TERMS-1].t0);
    g1f_r      <= g1_nxt;
    g2p_r      <= g1f_r;
    g2_pp_r    <= fmul_pp(g1f_r.y, g1f_r.t1);
    g2f_r      <= g2_nxt;
    g3p_r      <= g2f_r;
    g3_pp_r[0] <= fmul_pp(g2f_r.scale, g2f_r.y);
    for (int k = 0; k < MAX_TERMS; k++) g3_pp_r[k+1] <= fmul_pp(g2f_r.scale, g2f_r.b[k]);
    g3f_r      <= g3_nxt;
  end

  // ---------------- divider: prep, then one quotient bit per stage ----------------
  logic dv_v_r [DW+1];
  dv_t  dv_r   [DW+1];
  dv_t  d0_nxt;

  always_comb begin
    d0_nxt      = '0;
    d0_nxt.last = g3f_r.last;
    d0_nxt.rat  = g3f_r.rat;
    d0_nxt.meas = g3f_r.meas;
    d0_nxt.fit  = g3f_r.fit;
    d0_nxt.b    = g3f_r.b;
    d0_nxt.nm   = fx_mag(g3f_r.num);
    d0_nxt.dm   = fx_mag(g3f_r.den);
    d0_nxt.qneg = g3f_r.num[DW-1] ^ g3f_r.den[DW-1];
    d0_nxt.dz   = (g3f_r.den == '0);
    // quotient would need more than DW bits
    d0_nxt.ovf  = ((2*DW-FW)'(d0_nxt.nm) >= {d0_nxt.dm, {(DW-FW){1'b0}}});
    d0_nxt.rem  = d0_nxt.nm >> (DW - FW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else        dv_v_r[0] <= g3f_v_r;
  end

  always_ff @(posedge clk) begin
    dv_r[0] <= d0_nxt;
  end

  generate
    for (genvar s = 0; s < DW; s++) begin : g_div
      localparam int BI = DW - 1 - s;
      logic          nbit;
      logic [DW:0]   rs;
      logic          ge;
      dv_t           d_nxt;

      if (BI >= FW) begin : g_bit
        assign nbit = dv_r[s].nm[BI-FW];
      end else begin : g_zero
        assign nbit = 1'b0;
      end

      assign rs = {dv_r[s].rem, nbit};
      assign ge = (rs >= {1'b0, dv_r[s].dm});

      always_comb begin
        d_nxt     = dv_r[s];
        d_nxt.rem = ge ? DW'(rs - {1'b0, dv_r[s].dm}) : rs[DW-1:0];
        d_nxt.q   = {dv_r[s].q[DW-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) dv_v_r[s+1] <= 1'b0;
        else        dv_v_r[s+1] <= dv_v_r[s];
      end

      always_ff @(posedge clk) begin
        dv_r[s+1] <= d_nxt;
      end
    end
  endgenerate

  // ---------------- rounding and fault ----------------
  logic          rd_v_r;
  logic          rd_last_r, rd_fault_r;
  fx_t           rd_meas_r, rd_fit_r;
  fx_t [MAX_TERMS-1:0] rd_b_r;
  logic [DW:0]   q_rnd;
  fx_t           rd_fit_nxt;
  logic          rd_fault_nxt;
  dv_t           dl;

  assign dl    = dv_r[DW];
  assign q_rnd = {1'b0, dl.q} + (DW+1)'(dl.rem >= (dl.dm - dl.rem));

  always_comb begin
    rd_fit_nxt   = dl.fit;
    rd_fault_nxt = 1'b0;
    if (dl.rat) begin
      if (dl.dz) begin
        rd_fit_nxt   = '0;
        rd_fault_nxt = 1'b1;
      end else if (dl.ovf) begin
        rd_fit_nxt = dl.qneg ? FX_MIN : FX_MAX;
      end else begin
        rd_fit_nxt = sat_mag(dl.qneg, xw_t'(q_rnd));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_v_r <= 1'b0;
    else        rd_v_r <= dv_v_r[DW];
  end

  always_ff @(posedge clk) begin
    rd_last_r  <= dl.last;
    rd_meas_r  <= dl.meas;
    rd_fit_r   <= rd_fit_nxt;
    rd_fault_r <= rd_fault_nxt;
    rd_b_r     <= dl.b;
  end

  // ---------------- output register ----------------
  logic      out_v_r;
  out_word_t out_r, out_nxt;

  always_comb begin
    out_nxt.fitted       = rd_fit_r;
    out_nxt.residual     = ssub(rd_meas_r, rd_fit_r);
    out_nxt.basis_0      = rd_b_r[0];
    out_nxt.basis_1      = rd_b_r[1];
    out_nxt.basis_2      = rd_b_r[2];
    out_nxt.basis_3      = rd_b_r[3];
    out_nxt.basis_4      = rd_b_r[4];
    out_nxt.basis_5      = rd_b_r[5];
    out_nxt.divide_fault = rd_fault_r;
    out_nxt.last_out     = rd_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else        out_v_r <= rd_v_r;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_v_r;
  assign out_word   = out_r;

endmodule
